// ===== hdl/vm16_pkg.sv =====
// vm16_pkg: shared types and constants of the 16-bit instruction step machine.
// Used by vm16_regfile and vm16_instruction_step; depends on nothing else.
`default_nettype none

package vm16_pkg;

    // register file geometry
    localparam int REG_COUNT = 16;
    localparam int REG_AW    = 4;

    // fixed field widths of the item ports
    localparam int WORD_W    = 16;
    localparam int PC_OUT_W  = 12;

    // reset start address, subroutine entry and ADD flag limit
    localparam logic [15:0] START_RESET = 16'h0300;
    localparam logic [15:0] JSR_TARGET  = 16'h0100;
    localparam logic [15:0] ADD_LIMIT   = 16'd255;

    // configuration register indexes
    localparam logic REG_START = 1'b0;

    // operation codes
    localparam logic [3:0] OP_ADD  = 4'h0;
    localparam logic [3:0] OP_SUB  = 4'h1;
    localparam logic [3:0] OP_AND  = 4'h2;
    localparam logic [3:0] OP_OR   = 4'h3;
    localparam logic [3:0] OP_XOR  = 4'h4;
    localparam logic [3:0] OP_JMP  = 4'h5;
    localparam logic [3:0] OP_CALL = 4'h6;
    localparam logic [3:0] OP_RET  = 4'h7;
    localparam logic [3:0] OP_JSR  = 4'h8;
    localparam logic [3:0] OP_LD   = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_MOV  = 4'hB;
    localparam logic [3:0] OP_ST   = 4'hC;
    localparam logic [3:0] OP_INC  = 4'hD;
    localparam logic [3:0] OP_DEC  = 4'hE;
    localparam logic [3:0] OP_BEQ  = 4'hF;

    // register file write request
    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } rf_wr_t;

endpackage

`default_nettype wire

// ===== hdl/vm16_instruction_step.sv =====
// vm16_instruction_step: top level of the 16-bit instruction step machine.
// Depends on vm16_pkg and vm16_regfile.
//
// Each input item either writes one word into word memory (tuser low) or
// executes one instruction (tuser high); either way it returns one result item. An
// item passes through an accept cycle, which issues the instruction fetch
// from the synchronous word memory, a decode cycle, which reads the register
// file, the return stack and, for loads, the word memory, and an execute
// cycle, which writes everything back. The next item is accepted in the
// execute cycle of the previous one once the result register is free, with
// the new program counter fed straight to the fetch port. A store and a
// fetch of the same word in the same cycle are resolved by forwarding.
// Writing start_address also reloads the program counter; the user must
// write it only while the block is idle, as the block does not enforce it.
`default_nettype none

module vm16_instruction_step
    import vm16_pkg::*;
#(
    parameter int ADDR_BITS   = 12,
    parameter int STACK_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // load_address[11:0], load_data[27:12], zero pad
    input  wire logic        s_tuser,   // mode
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // next_pc[11:0], fetched_word[27:12],
                                        // dest_index[31:28], dest_value[47:32],
                                        // flag_out[48], stack_fault[49], zero pad
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int MEM_WORDS = 1 << ADDR_BITS;
    localparam int STK_IW    = $clog2(STACK_DEPTH);
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_DEC, ST_EXE} state_t;

    state_t                 state_reg;
    logic                   mode_reg;
    logic [ADDR_BITS-1:0]   ld_addr_reg;
    logic [WORD_W-1:0]      ld_data_reg;
    logic [ADDR_BITS-1:0]   pc_reg;
    logic [PC_OUT_W-1:0]    start_reg;
    logic                   flag_reg;
    logic [CNT_W-1:0]       stk_cnt_reg;
    logic [WORD_W-1:0]      instr_reg;
    logic                   m_tvalid_reg;
    logic [55:0]            m_tdata_reg;

    // word memory and its ports
    logic [WORD_W-1:0]      word_mem [MEM_WORDS];
    logic [WORD_W-1:0]      mem_q_reg;
    logic                   mem_rd_en;
    logic [ADDR_BITS-1:0]   mem_rd_addr;
    logic                   mem_we_raw;
    logic                   mem_we;
    logic [ADDR_BITS-1:0]   mem_wa;
    logic [WORD_W-1:0]      mem_wd;
    logic                   fwd_hit_reg;
    logic [WORD_W-1:0]      fwd_data_reg;

    // return stack memory and its ports
    logic [WORD_W-1:0]      stk_mem [STACK_DEPTH];
    logic [WORD_W-1:0]      stk_q_reg;
    logic [CNT_W-1:0]       cnt_m1;
    logic                   stk_we_raw;
    logic [WORD_W-1:0]      stk_wd;
    logic [CNT_W-1:0]       cnt_new;

    // register file
    rf_wr_t                 rf_wr;
    logic                   rf_we_raw;
    logic [WORD_W-1:0]      rf_wd;
    logic [WORD_W-1:0]      rx;
    logic [WORD_W-1:0]      ry;

    // handshake and decode
    logic                   s_acc;
    logic                   out_free;
    logic                   exe_done;
    logic                   cfg_wr;
    logic [WORD_W-1:0]      fetched_w;
    logic [ADDR_BITS-1:0]   fetch_pc;
    logic [3:0]             op;
    logic [REG_AW-1:0]      x_idx;
    logic [7:0]             imm;
    logic [ADDR_BITS-1:0]   pc_inc;
    logic [ADDR_BITS-1:0]   pc_new;
    logic                   flag_new;
    logic                   fault;
    logic [WORD_W-1:0]      sum;
    logic [WORD_W-1:0]      dval;
    logic [WORD_W-1:0]      out_fetched;
    logic [REG_AW-1:0]      out_x;
    logic [WORD_W-1:0]      out_dval;
    logic                   stk_empty;
    logic                   stk_full;

    // handshakes
    assign out_free = !m_tvalid_reg || m_tready;
    assign exe_done = (state_reg == ST_EXE) && out_free;
    assign s_tready = (state_reg == ST_IDLE) || exe_done;
    assign s_acc    = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_START);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_START) ? {20'd0, start_reg} : 32'd0;

    // fetched word comes from the memory or from a store forwarded in the fetch cycle
    assign fetched_w = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

    // execute-stage decode of the held instruction
    assign op     = instr_reg[15:12];
    assign x_idx  = instr_reg[11:8];
    assign imm    = instr_reg[7:0];
    assign pc_inc = pc_reg + ADDR_BITS'(1);
    assign sum    = rx + ry;
    assign cnt_m1 = stk_cnt_reg - CNT_W'(1);
    assign stk_empty = (stk_cnt_reg == '0);
    assign stk_full  = (stk_cnt_reg >= CNT_W'(STACK_DEPTH));

    // execute: new register value, flag, stack and program counter
    always_comb begin
        pc_new     = pc_reg;
        flag_new   = flag_reg;
        fault      = 1'b0;
        rf_we_raw  = 1'b0;
        rf_wd      = rx;
        stk_we_raw = 1'b0;
        stk_wd     = rx;
        cnt_new    = stk_cnt_reg;
        mem_we_raw = 1'b0;
        mem_wa     = ld_addr_reg;
        mem_wd     = ld_data_reg;
        if (!mode_reg) begin
            mem_we_raw = 1'b1;
        end else begin
            pc_new = pc_inc;
            case (op)
                OP_ADD: begin
                    rf_we_raw = 1'b1;
                    rf_wd     = sum;
                    flag_new  = (sum < ADD_LIMIT);
                end
                OP_SUB: begin
                    rf_we_raw = 1'b1;
                    rf_wd     = rx - ry;
                end
                OP_AND: begin
                    rf_we_raw = 1'b1;
                    rf_wd     = rx & ry;
                end
                OP_OR: begin
                    rf_we_raw = 1'b1;
                    rf_wd     = rx | ry;
                end
                OP_XOR: begin
                    rf_we_raw = 1'b1;
                    rf_wd     = rx ^ ry;
                end
                OP_JMP: begin
                    if (stk_empty) begin
                        fault = 1'b1;
                    end else begin
                        pc_new = ADDR_BITS'(stk_q_reg);
                    end
                end
                OP_CALL: begin
                    if (stk_full) begin
                        fault = 1'b1;
                    end else begin
                        stk_we_raw = 1'b1;
                        stk_wd     = rx;
                        cnt_new    = stk_cnt_reg + CNT_W'(1);
                        pc_new     = ADDR_BITS'(rx);
                    end
                end
                OP_RET: begin
                    if (stk_empty) begin
                        fault = 1'b1;
                    end else begin
                        pc_new  = ADDR_BITS'(stk_q_reg);
                        cnt_new = cnt_m1;
                    end
                end
                OP_JSR: begin
                    if (stk_full) begin
                        fault = 1'b1;
                    end else begin
                        stk_we_raw = 1'b1;
                        stk_wd     = WORD_W'(pc_inc) + WORD_W'(1);
                        cnt_new    = stk_cnt_reg + CNT_W'(1);
                        pc_new     = ADDR_BITS'(JSR_TARGET);
                    end
                end
                OP_LD: begin
                    rf_we_raw = 1'b1;
                    rf_wd     = mem_q_reg;
                end
                OP_LDI: begin
                    rf_we_raw = 1'b1;
                    rf_wd     = WORD_W'(imm);
                end
                OP_MOV: begin
                    rf_we_raw = 1'b1;
                    rf_wd     = ry;
                end
                OP_ST: begin
                    mem_we_raw = 1'b1;
                    mem_wa     = ADDR_BITS'(imm);
                    mem_wd     = rx;
                end
                OP_INC: begin
                    rf_we_raw = 1'b1;
                    rf_wd     = rx + WORD_W'(1);
                end
                OP_DEC: begin
                    rf_we_raw = 1'b1;
                    rf_wd     = rx - WORD_W'(1);
                end
                default: begin
                    // branch when the flag is clear
                    if (!flag_reg) begin
                        pc_new = ADDR_BITS'(imm);
                    end
                end
            endcase
        end
    end

    assign dval = rf_we_raw ? rf_wd : rx;

    // side effects happen only at the edge where the item completes
    assign mem_we      = exe_done && mem_we_raw;
    assign rf_wr.we    = exe_done && rf_we_raw;
    assign rf_wr.addr  = x_idx;
    assign rf_wr.data  = rf_wd;

    // word memory read port: fetch at accept, load operand in decode
    assign fetch_pc    = (state_reg == ST_EXE) ? pc_new : pc_reg;
    assign mem_rd_en   = (s_acc && s_tuser) || ((state_reg == ST_DEC) && mode_reg);
    assign mem_rd_addr = (state_reg == ST_DEC) ? ADDR_BITS'(fetched_w[7:0]) : fetch_pc;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            word_mem[mem_wa] <= mem_wd;
        end
        if (mem_rd_en) begin
            mem_q_reg <= word_mem[mem_rd_addr];
        end
    end

    // return stack: top read in decode, push in execute
    always_ff @(posedge aclk) begin
        if (exe_done && stk_we_raw) begin
            stk_mem[stk_cnt_reg[STK_IW-1:0]] <= stk_wd;
        end
        if (state_reg == ST_DEC) begin
            stk_q_reg <= stk_mem[cnt_m1[STK_IW-1:0]];
        end
    end

    vm16_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (state_reg == ST_DEC),
        .rd_addr_a (fetched_w[11:8]),
        .rd_addr_b (fetched_w[7:4]),
        .wr        (rf_wr),
        .rd_data_a (rx),
        .rd_data_b (ry)
    );

    // result fields; a memory write item reports zeros in the fetched word, index and value
    assign out_fetched = mode_reg ? instr_reg : '0;
    assign out_x       = mode_reg ? x_idx : '0;
    assign out_dval    = mode_reg ? dval : '0;

    // sequencer, architectural state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_reg    <= PC_OUT_W'(ADDR_BITS'(START_RESET));
            pc_reg       <= ADDR_BITS'(START_RESET);
            flag_reg     <= 1'b0;
            stk_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            // drained result clears unless a new one is loaded at the same edge
            if (m_tvalid_reg && m_tready && !exe_done) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        state_reg <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    state_reg <= ST_EXE;
                end
                ST_EXE: begin
                    if (out_free) begin
                        state_reg    <= s_acc ? ST_DEC : ST_IDLE;
                        pc_reg       <= pc_new;
                        flag_reg     <= flag_new;
                        stk_cnt_reg  <= cnt_new;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, fault, flag_new, out_dval, out_x,
                                         out_fetched, PC_OUT_W'(pc_new)};
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (s_acc) begin
                fwd_hit_reg <= mem_we && (mem_wa == fetch_pc);
            end
            if (cfg_wr) begin
                start_reg <= PC_OUT_W'(ADDR_BITS'(pwdata[11:0]));
                pc_reg    <= ADDR_BITS'(pwdata[11:0]);
            end
        end
    end

    // item and pipeline payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            mode_reg     <= s_tuser;
            ld_addr_reg  <= ADDR_BITS'(s_tdata[11:0]);
            ld_data_reg  <= s_tdata[27:12];
            fwd_data_reg <= mem_wd;
        end
        if (state_reg == ST_DEC) begin
            instr_reg <= fetched_w;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // the stack never holds more than its depth
    a_stk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // a faulting step leaves the stack count alone
    a_fault_stk: assert property (@(posedge aclk) disable iff (!aresetn)
        exe_done && fault |=> $stable(stk_cnt_reg))
        else $error("stack changed on fault");

    // an accepted item always moves to decode
    a_acc_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> state_reg == ST_DEC)
        else $error("accepted item did not enter decode");

    // a completed execute always presents a result
    a_exe_out: assert property (@(posedge aclk) disable iff (!aresetn)
        exe_done |=> m_tvalid)
        else $error("execute completed without result");

    // decode is always followed by execute
    a_dec_exe: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DEC |=> state_reg == ST_EXE)
        else $error("decode not followed by execute");
`endif

endmodule

`default_nettype wire

// ===== hdl/vm16_regfile.sv =====
// vm16_regfile: 16 x 16 register file, two registered read ports, one write port.
// Entries read as zero until first written. Depends on vm16_pkg.
`default_nettype none

module vm16_regfile
    import vm16_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [REG_AW-1:0] rd_addr_a,
    input  wire logic [REG_AW-1:0] rd_addr_b,
    input  wire rf_wr_t            wr,
    output logic      [WORD_W-1:0] rd_data_a,
    output logic      [WORD_W-1:0] rd_data_b
);

    logic [WORD_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [WORD_W-1:0]    rd_a_reg;
    logic [WORD_W-1:0]    rd_b_reg;

    // valid bits stand in for the all-zero reset of the array
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.we) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // storage write
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= valid_reg[rd_addr_a] ? mem[rd_addr_a] : '0;
            rd_b_reg <= valid_reg[rd_addr_b] ? mem[rd_addr_b] : '0;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== tb/tb_vm16_instruction_step.sv =====
// tb_vm16_instruction_step: self-checking testbench of the 16-bit instruction step machine.
// Depends on vm16_pkg and vm16_instruction_step; keeps its own model of the machine state.
`timescale 1ns / 1ps

module tb_vm16_instruction_step;
    import vm16_pkg::*;

    localparam int ADDR_BITS    = 12;
    localparam int STACK_DEPTH  = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 200;
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_EXEC  = 1'b1;

    // one result item, field by field
    typedef struct packed {
        logic [11:0] next_pc;
        logic [15:0] fetched_word;
        logic [3:0]  dest_index;
        logic [15:0] dest_value;
        logic        flag_out;
        logic        stack_fault;
    } step_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // load_address[11:0], load_data[27:12], zero pad
    logic        s_tuser = 1'b0;   // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // next_pc[11:0], fetched_word[27:12], dest_index[31:28],
                                   // dest_value[47:32], flag_out[48], stack_fault[49], zero pad
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // machine state as the testbench sees it
    logic [11:0] pc_q;
    logic [11:0] start_q;
    logic [15:0] regs_q [16];
    logic [15:0] mem_q [4096];
    bit          written_q [4096];
    logic [15:0] stack_q [STACK_DEPTH];
    int unsigned depth_q;
    logic        flag_q;

    step_result_t pending_steps[$];
    int unsigned  items_sent = 0;
    int unsigned  fail_count = 0;
    bit           no_idle = 1'b0;
    int unsigned  hold_requests = 0;
    int unsigned  hold_served = 0;
    int unsigned  hold_left = 0;

    vm16_instruction_step #(
        .ADDR_BITS(ADDR_BITS),
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #6 aclk = ~aclk;

    task automatic report_failure(input string msg);
        if (fail_count < 40)
            $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    // state after reset
    task automatic reset_machine_state();
        start_q = START_RESET[11:0];
        pc_q    = start_q;
        depth_q = 0;
        flag_q  = 1'b0;
        foreach (regs_q[i]) regs_q[i] = '0;
        foreach (written_q[i]) written_q[i] = 1'b0;
    endtask

    // one step of the machine; updates the state and returns the result item
    function automatic step_result_t machine_step(input logic mode, input logic [11:0] addr,
                                                  input logic [15:0] data);
        step_result_t r;
        logic [15:0] w;
        logic [3:0]  op, x, y;
        logic [7:0]  imm;
        r = '0;
        if (mode == MODE_LOAD) begin
            mem_q[addr]     = data;
            written_q[addr] = 1'b1;
        end else begin
            w    = mem_q[pc_q];
            pc_q = pc_q + 12'd1;
            op   = w[15:12];
            x    = w[11:8];
            y    = w[7:4];
            imm  = w[7:0];
            case (op)
                OP_ADD: begin
                    regs_q[x] = regs_q[x] + regs_q[y];
                    flag_q    = (regs_q[x] < ADD_LIMIT);
                end
                OP_SUB: regs_q[x] = regs_q[x] - regs_q[y];
                OP_AND: regs_q[x] = regs_q[x] & regs_q[y];
                OP_OR:  regs_q[x] = regs_q[x] | regs_q[y];
                OP_XOR: regs_q[x] = regs_q[x] ^ regs_q[y];
                OP_JMP: begin
                    if (depth_q == 0) r.stack_fault = 1'b1;
                    else pc_q = stack_q[depth_q - 1][11:0];
                end
                OP_CALL: begin
                    if (depth_q == STACK_DEPTH) begin
                        r.stack_fault = 1'b1;
                    end else begin
                        stack_q[depth_q] = regs_q[x];
                        depth_q++;
                        pc_q = regs_q[x][11:0];
                    end
                end
                OP_RET: begin
                    if (depth_q == 0) begin
                        r.stack_fault = 1'b1;
                    end else begin
                        pc_q = stack_q[depth_q - 1][11:0];
                        depth_q--;
                    end
                end
                OP_JSR: begin
                    // return address is one past the post-fetch pc, kept at 16 bits
                    if (depth_q == STACK_DEPTH) begin
                        r.stack_fault = 1'b1;
                    end else begin
                        stack_q[depth_q] = {4'h0, pc_q} + 16'd1;
                        depth_q++;
                        pc_q = JSR_TARGET[11:0];
                    end
                end
                OP_LD:  regs_q[x] = mem_q[{4'h0, imm}];
                OP_LDI: regs_q[x] = {8'h00, imm};
                OP_MOV: regs_q[x] = regs_q[y];
                OP_ST: begin
                    mem_q[{4'h0, imm}]     = regs_q[x];
                    written_q[{4'h0, imm}] = 1'b1;
                end
                OP_INC: regs_q[x] = regs_q[x] + 16'd1;
                OP_DEC: regs_q[x] = regs_q[x] - 16'd1;
                OP_BEQ: if (!flag_q) pc_q = {4'h0, imm};
            endcase
            r.fetched_word = w;
            r.dest_index   = x;
            r.dest_value   = regs_q[x];
        end
        r.next_pc  = pc_q;
        r.flag_out = flag_q;
        return r;
    endfunction

    // offer one item, with random gaps, and log its expected result once accepted
    task automatic send_item(input logic mode, input logic [11:0] addr, input logic [15:0] data);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 20) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'h0, data, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_steps.insert(pending_steps.size(), machine_step(mode, addr, data));
        items_sent++;
    endtask

    // sender pauses until every expected result has come back
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_steps.size() != 0) @(posedge aclk);
    endtask

    // APB write of start_address, only with the machine idle
    task automatic write_start_address(input logic [11:0] value);
        wait_results_done();
        repeat (2) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_START, 2'b00};
        pwdata  <= {20'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        start_q = value;
        pc_q    = value;
    endtask

    // place a word at pc if needed, then execute it; a load never touches unwritten memory
    task automatic run_instruction(input logic [15:0] w);
        if (w[15:12] == OP_LD && !written_q[{4'h0, w[7:0]}])
            send_item(MODE_LOAD, {4'h0, w[7:0]}, 16'($urandom));
        if (!written_q[pc_q] || mem_q[pc_q] != w)
            send_item(MODE_LOAD, pc_q, w);
        send_item(MODE_EXEC, 12'($urandom), 16'($urandom));
    endtask

    function automatic logic [15:0] random_instruction();
        logic [15:0] w;
        w = 16'($urandom);
        // plenty of small immediates so that ADD results fall on both sides of the limit
        if ($urandom_range(0, 3) == 0) w[15:12] = OP_LDI;
        return w;
    endfunction

    // execute whatever program already sits at pc (stored or jumped-to code)
    task automatic run_stored_instruction();
        logic [15:0] w;
        if (!written_q[pc_q]) begin
            run_instruction(random_instruction());
        end else begin
            w = mem_q[pc_q];
            if (w[15:12] == OP_LD && !written_q[{4'h0, w[7:0]}])
                send_item(MODE_LOAD, {4'h0, w[7:0]}, 16'($urandom));
            send_item(MODE_EXEC, 12'($urandom), 16'($urandom));
        end
    endtask

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(0, 99) >= 20);
        end
    end

    // result check against the oldest expected step
    always @(posedge aclk) begin : check_results
        step_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.next_pc      = m_tdata[11:0];
            got.fetched_word = m_tdata[27:12];
            got.dest_index   = m_tdata[31:28];
            got.dest_value   = m_tdata[47:32];
            got.flag_out     = m_tdata[48];
            got.stack_fault  = m_tdata[49];
            if (pending_steps.size() == 0) begin
                report_failure($sformatf("result item with no step pending: 0x%0h", m_tdata));
            end else begin
                want = pending_steps.pop_front();
                if (got.next_pc != want.next_pc)
                    report_failure($sformatf("next_pc 0x%0h, expected 0x%0h",
                                             got.next_pc, want.next_pc));
                if (got.fetched_word != want.fetched_word)
                    report_failure($sformatf("fetched_word 0x%0h, expected 0x%0h",
                                             got.fetched_word, want.fetched_word));
                if (got.dest_index != want.dest_index)
                    report_failure($sformatf("dest_index %0d, expected %0d",
                                             got.dest_index, want.dest_index));
                if (got.dest_value != want.dest_value)
                    report_failure($sformatf("dest_value 0x%0h, expected 0x%0h",
                                             got.dest_value, want.dest_value));
                if (got.flag_out != want.flag_out)
                    report_failure($sformatf("flag_out %0b, expected %0b",
                                             got.flag_out, want.flag_out));
                if (got.stack_fault != want.stack_fault)
                    report_failure($sformatf("stack_fault %0b, expected %0b",
                                             got.stack_fault, want.stack_fault));
            end
        end
    end

    // every operation once, field extremes, wrap and truncated jump targets
    task automatic test_each_operation();
        send_item(MODE_LOAD, 12'hFFF, 16'hFFFF);
        send_item(MODE_LOAD, 12'h000, 16'h0000);
        run_instruction({OP_LDI, 4'h1, 8'hFF});
        run_instruction({OP_LDI, 4'h2, 8'h01});
        run_instruction({OP_ADD, 4'h1, 4'h2, 4'h0});    // 0x100, flag clear
        run_instruction({OP_SUB, 4'h2, 4'h1, 4'h0});    // wraps below zero
        run_instruction({OP_AND, 4'h2, 4'h1, 4'h0});
        run_instruction({OP_OR,  4'h3, 4'h2, 4'h0});
        run_instruction({OP_XOR, 4'h3, 4'h3, 4'h0});
        run_instruction({OP_DEC, 4'h3, 8'h00});         // 0 -> 0xFFFF
        run_instruction({OP_INC, 4'h3, 8'h00});         // 0xFFFF -> 0
        run_instruction({OP_ADD, 4'h3, 4'h3, 4'h0});    // flag set
        run_instruction({OP_BEQ, 4'h0, 8'h80});         // not taken
        run_instruction({OP_ST,  4'h1, 8'h40});
        run_instruction({OP_LD,  4'hF, 8'h40});
        run_instruction({OP_MOV, 4'hE, 4'hF, 4'h0});
        run_instruction({OP_ADD, 4'h1, 4'h1, 4'h0});    // flag clear again
        run_instruction({OP_BEQ, 4'hF, 8'hFF});         // taken
        run_instruction({OP_JSR, 12'h000});
        run_instruction({OP_JMP, 12'h000});
        run_instruction({OP_RET, 12'h000});
        run_instruction({OP_RET, 12'h000});             // empty stack
        run_instruction({OP_JMP, 12'h000});             // empty stack
        run_instruction({OP_DEC, 4'h6, 8'h00});
        run_instruction({OP_CALL, 4'h6, 8'h00});        // target above 12 bits
        run_instruction({OP_RET, 12'h000});
        run_instruction({OP_XOR, 4'hF, 4'hF, 4'hF});    // pc wraps to zero
    endtask

    // start_address at its extremes and elsewhere
    task automatic test_start_address();
        write_start_address(12'hFFE);
        run_instruction({OP_JSR, 12'h000});             // pushes 0x1000
        run_instruction({OP_RET, 12'h000});             // lands on 0
        write_start_address(12'h000);
        run_instruction({OP_LDI, 4'h9, 8'h5A});
        write_start_address(12'hFFF);
        run_instruction({OP_MOV, 4'h9, 4'h3, 4'h0});
        write_start_address(12'($urandom));
        run_instruction(random_instruction());
        write_start_address(START_RESET[11:0]);
    endtask

    // fill the return stack past its depth, then drain it past empty
    task automatic test_stack_limits();
        run_instruction({OP_JSR, 12'h000});
        while (depth_q < STACK_DEPTH) run_instruction({OP_JSR, 12'h000});
        run_instruction({OP_JSR, 12'h000});
        run_instruction({OP_CALL, 4'h1, 8'h00});
        while (depth_q > 0) run_instruction({OP_RET, 12'h000});
        run_instruction({OP_RET, 12'h000});
        run_instruction({OP_JMP, 12'h000});
    endtask

    // a long stretch without idling on either side
    task automatic test_back_to_back();
        wait_results_done();
        no_idle = 1'b1;
        repeat (20) run_instruction(random_instruction());
        wait_results_done();
        no_idle = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so the block stalls its input
    task automatic test_stall_pressure();
        hold_requests++;
        repeat (30) run_instruction(random_instruction());
        wait_results_done();
    endtask

    // mostly real programs, some stored code, some stray memory writes
    task automatic test_random_program();
        int unsigned stop_at;
        int unsigned pick;
        for (int round = 0; round < 4; round++) begin
            if (round != 0) write_start_address(12'($urandom));
            stop_at = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < stop_at) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    run_instruction(random_instruction());
                else if (pick < 88)
                    run_stored_instruction();
                else
                    send_item(MODE_LOAD, 12'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        reset_machine_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_each_operation();
        test_start_address();
        test_stack_limits();
        test_back_to_back();
        test_stall_pressure();
        test_random_program();

        wait_results_done();
        repeat (20) @(posedge aclk);
        if (pending_steps.size() != 0)
            report_failure($sformatf("%0d results never arrived", pending_steps.size()));
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(2_000_000);
        $display("status: fail");
        $finish;
    end

endmodule
